// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define BMFC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must never be true outside reset
`define BMFC_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BMFC_ASSERT(label, clk, rst, prop, msg)
`define BMFC_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== sv/bmfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmfc_pkg
// shared types and constants of the band mode fraction check
// ----------------------------------------------------------------------------
package bmfc_pkg;

   localparam int SAMPLE_W      = 16;   // sample port width
   localparam int OUT_BITS      = 24;   // count field width on the result port
   localparam int EPOCH_BITS    = 16;   // band tag stored with each bin
   localparam int FIFO_DEPTH    = 4;    // result queue entries
   localparam int FIFO_PTR_BITS = 2;
   localparam int PEND_BITS     = 3;    // holds 0 .. FIFO_DEPTH

   typedef logic [EPOCH_BITS-1:0] epoch_type;

   // tag zero marks a cleared bin, live bands run from first to last
   localparam epoch_type EPOCH_CLEAR = '0;
   localparam epoch_type EPOCH_FIRST = epoch_type'(1);
   localparam epoch_type EPOCH_LAST  = '1;

   typedef struct packed {
      logic valid;
      logic last;
      logic flag;
   } stage_ctl_type;

   typedef struct packed {
      logic                concentrated;
      logic                reference_allowed;
      logic [OUT_BITS-1:0] mode_count;
      logic [OUT_BITS-1:0] band_samples;
   } rsp_type;

endpackage

// ===== sv/bmfc_hist_mem.sv =====
// ----------------------------------------------------------------------------
// bmfc_hist_mem
// histogram bin store, one write port and one registered read port
// ----------------------------------------------------------------------------
module bmfc_hist_mem #(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 40
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];

   // read returns the old word when the same bin is written in that cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/bmfc_update.sv =====
// ----------------------------------------------------------------------------
// bmfc_update
// bin increment with forwarding, band counters and result formation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bmfc_update import bmfc_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  stage_ctl_type                    s1_ctl,
   input  logic [SAMPLE_BITS-1:0]           s1_bin,
   input  epoch_type                        s1_epoch,
   input  logic [EPOCH_BITS+COUNT_BITS-1:0] rd_data,
   output logic                             wr_en,
   output logic [SAMPLE_BITS-1:0]           wr_addr,
   output logic [EPOCH_BITS+COUNT_BITS-1:0] wr_data,
   output logic                             res_valid,
   output rsp_type                          res
);

   localparam int ENTRY_BITS = EPOCH_BITS + COUNT_BITS;
   localparam int WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
   endfunction

   function automatic logic [OUT_BITS-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
      logic [WIDE_BITS-1:0] wide;
      logic [WIDE_BITS-1:0] lim;
      wide = WIDE_BITS'(v);
      lim  = WIDE_BITS'({OUT_BITS{1'b1}});
      return (wide > lim) ? lim[OUT_BITS-1:0] : wide[OUT_BITS-1:0];
   endfunction

   epoch_type               rd_epoch;
   logic [COUNT_BITS-1:0]   rd_count;
   logic                    fwd_valid_ff;
   logic [SAMPLE_BITS-1:0]  fwd_bin_ff;
   epoch_type               fwd_epoch_ff;
   logic [COUNT_BITS-1:0]   fwd_count_ff;
   logic                    fwd_hit;
   logic [COUNT_BITS-1:0]   base_count;
   logic [COUNT_BITS-1:0]   bin_count;
   logic [COUNT_BITS-1:0]   band_best;
   logic [COUNT_BITS-1:0]   band_total;
   logic [COUNT_BITS-1:0]   best_ff, best_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;
   logic                    res_valid_ff;
   logic                    res_flag_ff;
   logic [COUNT_BITS-1:0]   res_best_ff;
   logic [COUNT_BITS-1:0]   res_total_ff;
   logic [COUNT_BITS+3:0]   tenfold;
   logic                    conc;

   assign rd_epoch = rd_data[ENTRY_BITS-1 -: EPOCH_BITS];
   assign rd_count = rd_data[COUNT_BITS-1:0];

   // previous cycle's write is not yet visible in the read word
   assign fwd_hit = fwd_valid_ff && (fwd_bin_ff == s1_bin) && (fwd_epoch_ff == s1_epoch);

   always_comb begin
      if (fwd_hit) begin
         base_count = fwd_count_ff;
      end else if (rd_epoch == s1_epoch) begin
         base_count = rd_count;
      end else begin
         base_count = '0;
      end
   end

   assign bin_count  = sat_inc(base_count);
   assign band_best  = (bin_count > best_ff) ? bin_count : best_ff;
   assign band_total = sat_inc(total_ff);

   assign wr_en   = s1_ctl.valid;
   assign wr_addr = s1_bin;
   assign wr_data = {s1_epoch, bin_count};

   always_comb begin
      best_in  = best_ff;
      total_in = total_ff;
      if (s1_ctl.valid) begin
         if (s1_ctl.last) begin
            best_in  = '0;
            total_in = '0;
         end else begin
            best_in  = band_best;
            total_in = band_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         best_ff      <= '0;
         total_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= s1_ctl.valid;
         best_ff      <= best_in;
         total_ff     <= total_in;
         res_valid_ff <= s1_ctl.valid && s1_ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      fwd_bin_ff   <= s1_bin;
      fwd_epoch_ff <= s1_epoch;
      fwd_count_ff <= bin_count;
      if (s1_ctl.valid && s1_ctl.last) begin
         res_best_ff  <= band_best;
         res_total_ff <= band_total;
         res_flag_ff  <= s1_ctl.flag;
      end
   end

   // 10 * mode > samples, as 8x + 2x
   assign tenfold = ({4'b0000, res_best_ff} << 3) + ({4'b0000, res_best_ff} << 1);
   assign conc    = tenfold > {4'b0000, res_total_ff};

   assign res_valid             = res_valid_ff;
   assign res.concentrated      = conc;
   assign res.reference_allowed = res_flag_ff && !conc;
   assign res.mode_count        = clamp_out(res_best_ff);
   assign res.band_samples      = clamp_out(res_total_ff);

   `BMFC_NEVER(a_best_le_total, clock, reset, best_ff > total_ff, "mode count above sample count")
   `BMFC_ASSERT(a_clear_after_last, clock, reset, s1_ctl.valid && s1_ctl.last |=> best_ff == '0 && total_ff == '0, "band counters not cleared")

endmodule

// ===== sv/bmfc_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// bmfc_rsp_fifo
// small result queue in front of the rsp channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bmfc_rsp_fifo import bmfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    pop,
   output logic    out_valid,
   output rsp_type out_data
);

   rsp_type                  slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff;
   logic [FIFO_PTR_BITS:0]   fill_ff, fill_in;
   logic                     do_pop;

   assign out_valid = fill_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && out_valid;

   always_comb begin
      fill_in = fill_ff;
      if (push && !do_pop) begin
         fill_in = fill_ff + (FIFO_PTR_BITS+1)'(1);
      end else if (!push && do_pop) begin
         fill_in = fill_ff - (FIFO_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_BITS'(1);
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BMFC_NEVER(a_no_overflow, clock, reset, push && !do_pop && fill_ff == (FIFO_PTR_BITS+1)'(FIFO_DEPTH), "result queue overflow")

endmodule

// ===== sv/band_mode_fraction_check.sv =====
// result path: last sample beat -> stage 1 register -> result register -> result queue -> rsp
// throughput: one sample beat per cycle, set by one histogram read-modify-write
//   per cycle with one-deep write forwarding; req_ready drops while four results wait
// clearing: req_ready low while a pass writes all 2**SAMPLE_BITS bins, after reset
//   and after every 65535th band
// reset: synchronous active high; clears control and counters, sets the first value of the band tag
// ----------------------------------------------------------------------------
// band_mode_fraction_check
// per-band histogram of sample values with running mode count; on the band's
// last sample reports whether the mode exceeds one tenth of the band
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module band_mode_fraction_check import bmfc_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last_in_band,
   input  logic                       req_incoming_flag,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_concentrated,
   output logic                       rsp_reference_allowed,
   output logic [OUT_BITS-1:0]        rsp_mode_count,
   output logic [OUT_BITS-1:0]        rsp_band_samples
);

   localparam int ENTRY_BITS = EPOCH_BITS + COUNT_BITS;

   logic                   req_beat;
   logic                   rsp_beat;
   logic [SAMPLE_BITS-1:0] req_bin;

   // stage 1: bin word comes back from the memory
   stage_ctl_type          s1_ctl_ff;
   logic [SAMPLE_BITS-1:0] s1_bin_ff;
   epoch_type              s1_epoch_ff;

   // band tag; bins carrying another tag read as zero
   epoch_type              epoch_ff, epoch_in;

   // clearing pass over the bins
   logic                   sweep_ff;
   logic [SAMPLE_BITS-1:0] sweep_addr_ff;
   logic                   sweep_step;
   logic                   sweep_start;

   // results promised to the queue but not yet taken
   logic [PEND_BITS-1:0]   pend_ff, pend_in;

   logic                   upd_wr_en;
   logic [SAMPLE_BITS-1:0] upd_wr_addr;
   logic [ENTRY_BITS-1:0]  upd_wr_data;
   logic                   mem_wr_en;
   logic [SAMPLE_BITS-1:0] mem_wr_addr;
   logic [ENTRY_BITS-1:0]  mem_wr_data;
   logic [ENTRY_BITS-1:0]  mem_rd_data;

   logic                   res_valid;
   rsp_type                res;
   rsp_type                rsp_data;

   // ---------------------------------------------------------------- intake
   // a free queue slot is reserved at every last-sample beat
   assign req_ready = !sweep_ff && (pend_ff < PEND_BITS'(FIFO_DEPTH));
   assign req_beat  = req_valid && req_ready;
   assign req_bin   = req_sample[SAMPLE_BITS-1:0];

   // tag wraps back to the first live value and a fresh clearing pass begins
   assign sweep_start = req_beat && req_last_in_band && (epoch_ff == EPOCH_LAST);

   always_comb begin
      epoch_in = epoch_ff;
      if (req_beat && req_last_in_band) begin
         if (epoch_ff == EPOCH_LAST) begin
            epoch_in = EPOCH_FIRST;
         end else begin
            epoch_in = epoch_ff + epoch_type'(1);
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if ((req_beat && req_last_in_band) && !rsp_beat) begin
         pend_in = pend_ff + PEND_BITS'(1);
      end else if (!(req_beat && req_last_in_band) && rsp_beat) begin
         pend_in = pend_ff - PEND_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         epoch_ff  <= EPOCH_FIRST;
         pend_ff   <= '0;
      end else begin
         s1_ctl_ff.valid <= req_beat;
         s1_ctl_ff.last  <= req_last_in_band;
         s1_ctl_ff.flag  <= req_incoming_flag;
         epoch_ff        <= epoch_in;
         pend_ff         <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_bin_ff   <= req_bin;
      s1_epoch_ff <= epoch_ff;
   end

   // ---------------------------------------------------------------- clearing
   // the bin update has the write port first; the pass waits while it writes
   assign sweep_step = sweep_ff && !upd_wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else if (sweep_start) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else if (sweep_step) begin
         sweep_addr_ff <= sweep_addr_ff + SAMPLE_BITS'(1);
         if (sweep_addr_ff == '1) begin
            sweep_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- histogram
   assign mem_wr_en   = upd_wr_en || sweep_step;
   assign mem_wr_addr = upd_wr_en ? upd_wr_addr : sweep_addr_ff;
   assign mem_wr_data = upd_wr_en ? upd_wr_data : {EPOCH_CLEAR, {COUNT_BITS{1'b0}}};

   bmfc_hist_mem #(
      .ADDR_BITS (SAMPLE_BITS),
      .DATA_BITS (ENTRY_BITS)
   ) u_hist_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (req_bin),
      .rd_data (mem_rd_data)
   );

   bmfc_update #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .s1_ctl    (s1_ctl_ff),
      .s1_bin    (s1_bin_ff),
      .s1_epoch  (s1_epoch_ff),
      .rd_data   (mem_rd_data),
      .wr_en     (upd_wr_en),
      .wr_addr   (upd_wr_addr),
      .wr_data   (upd_wr_data),
      .res_valid (res_valid),
      .res       (res)
   );

   // ---------------------------------------------------------------- results
   assign rsp_beat = rsp_valid && rsp_ready;

   bmfc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign rsp_concentrated      = rsp_data.concentrated;
   assign rsp_reference_allowed = rsp_data.reference_allowed;
   assign rsp_mode_count        = rsp_data.mode_count;
   assign rsp_band_samples      = rsp_data.band_samples;

   `BMFC_NEVER(a_epoch_live, clock, reset, epoch_ff == EPOCH_CLEAR, "band tag equals cleared tag")
   `BMFC_NEVER(a_pend_bound, clock, reset, pend_ff > PEND_BITS'(FIFO_DEPTH), "more results pending than queue slots")
   `BMFC_NEVER(a_rsp_promised, clock, reset, rsp_valid && pend_ff == '0, "result beat with none pending")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the band mode fraction check: streams bands of
// samples with random gaps and stalls, predicts each band's mode count, sample
// count and concentration verdict, and compares every result beat in order
// ----------------------------------------------------------------------------
module tb_top;
   import bmfc_pkg::*;

   localparam int SAMPLE_BITS    = 16;
   localparam int COUNT_W        = 24;
   localparam int RANDOM_ITEMS   = 1550;
   localparam int HOLD_CYCLES    = 300;      // long receiver stall
   localparam int HOLD_BANDS     = 24;       // single-sample bands sent into the stall
   localparam int MAX_GAP        = 13;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int TAIL_CYCLES    = 8;        // margin for the result path
   localparam int TIMEOUT_CYCLES = 600000;   // clearing pass plus worst gaps, several times over

   typedef logic [COUNT_W-1:0] count_type;

   // -------------------------------------------------------------------------
   // band scoreboard: histogram of the current band and queue of band verdicts
   // -------------------------------------------------------------------------
   class band_mode_scoreboard;
      int unsigned bin_hits [logic [SAMPLE_BITS-1:0]];
      count_type   mode_hits;
      count_type   band_len;
      rsp_type     verdict_q [$];
      int unsigned errors;

      function new();
         errors = 0;
         clear_band();
      endfunction

      function void clear_band();
         bin_hits.delete();
         mode_hits = '0;
         band_len  = '0;
      endfunction

      function count_type sat_inc(count_type v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      // one accepted sample beat
      function void note_sample(logic [SAMPLE_W-1:0] sample, logic last, logic flag);
         logic [SAMPLE_BITS-1:0] bin;
         count_type              hits;
         rsp_type                v;
         logic                   conc;
         bin  = sample[SAMPLE_BITS-1:0];
         hits = bin_hits.exists(bin) ? count_type'(bin_hits[bin]) : '0;
         hits = sat_inc(hits);
         bin_hits[bin] = hits;
         if (hits > mode_hits) mode_hits = hits;
         band_len = sat_inc(band_len);
         if (last) begin
            // exact one-tenth test in integers
            conc = (64'(mode_hits) * 64'd10) > 64'(band_len);
            v.concentrated      = conc;
            v.reference_allowed = flag & ~conc;
            v.mode_count        = OUT_BITS'(mode_hits);
            v.band_samples      = OUT_BITS'(band_len);
            verdict_q.push_back(v);
            clear_band();
         end
      endfunction

      // one accepted result beat
      function void check_result(rsp_type got);
         rsp_type want;
         if (verdict_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: conc=%0b ref=%0b mode=%0d samples=%0d",
                        got.concentrated, got.reference_allowed, got.mode_count,
                        got.band_samples);
            return;
         end
         want = verdict_q.pop_front();
         if (got.concentrated      !== want.concentrated      ||
             got.reference_allowed !== want.reference_allowed ||
             got.mode_count        !== want.mode_count        ||
             got.band_samples      !== want.band_samples) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected conc=%0b ref=%0b mode=%0d samples=%0d, got conc=%0b ref=%0b mode=%0d samples=%0d",
                        want.concentrated, want.reference_allowed, want.mode_count,
                        want.band_samples, got.concentrated, got.reference_allowed,
                        got.mode_count, got.band_samples);
         end
      endfunction

      function int unsigned pending();
         return verdict_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_last_in_band = 1'b0;
   logic                       req_incoming_flag = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_concentrated;
   logic                       rsp_reference_allowed;
   logic [OUT_BITS-1:0]        rsp_mode_count;
   logic [OUT_BITS-1:0]        rsp_band_samples;

   band_mode_scoreboard sb;

   // sender and receiver idling controls
   bit          tx_quiet = 1'b0;    // no gaps on the request side
   bit          rx_quiet = 1'b0;    // no stalls on the response side
   bit          hold_rsp = 1'b0;    // asks the receiver for one long stall
   int unsigned items_sent = 0;

   always #5 clock = ~clock;

   band_mode_fraction_check #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_W)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample            (req_sample),
      .req_last_in_band      (req_last_in_band),
      .req_incoming_flag     (req_incoming_flag),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_concentrated      (rsp_concentrated),
      .rsp_reference_allowed (rsp_reference_allowed),
      .rsp_mode_count        (rsp_mode_count),
      .rsp_band_samples      (rsp_band_samples)
   );

   // -------------------------------------------------------------------------
   // monitors: both sides sampled at the rising edge, before any update lands
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_sample(req_sample, req_last_in_band, req_incoming_flag);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_concentrated, rsp_reference_allowed,
                          rsp_mode_count, rsp_band_samples});
   end

   // -------------------------------------------------------------------------
   // receiver: random stall per beat, quiet stretches, one long hold on request
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned stall;
      int unsigned beats;
      beats = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            // long stall counted here so the result queue backs up into req_ready
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats++;
         // switch between stalling and streaming now and then
         if (beats % 16 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      end
   end

   // -------------------------------------------------------------------------
   // sender tasks
   // -------------------------------------------------------------------------

   // one sample beat, with a random gap ahead of it unless the sender is quiet
   task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic last, logic flag);
      int unsigned gap;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample        <= sample;
      req_last_in_band  <= last;
      req_incoming_flag <= flag;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // drop valid and wait until every band verdict has come back or the limit is reached
   task automatic wait_idle(int unsigned limit);
      int unsigned n;
      n = 0;
      req_valid <= 1'b0;
      @(posedge clock);    // lets the monitor note the last accepted beat
      while (sb.pending() != 0 && n < limit) begin
         @(posedge clock);
         n++;
      end
   endtask

   // one random band: short, medium or long, drawn from the full value range or from
   // a small pool with one favored value so the verdict lands on both sides of one tenth
   task automatic send_random_band();
      logic [SAMPLE_W-1:0] pool [16];
      int unsigned         pool_size;
      int unsigned         heavy_pct;
      int unsigned         len;
      int unsigned         r;
      int unsigned         i;
      logic [SAMPLE_W-1:0] s;
      bit                  full_range;
      logic                flag;
      r = $urandom_range(0, 99);
      if (r < 10)      len = 1;
      else if (r < 85) len = $urandom_range(2, 24);
      else             len = $urandom_range(25, 100);
      full_range = ($urandom_range(0, 4) == 0);
      pool_size  = $urandom_range(1, 16);
      heavy_pct  = $urandom_range(0, 60);
      for (i = 0; i < 16; i++) pool[i] = SAMPLE_W'($urandom);
      flag     = $urandom_range(0, 1);
      tx_quiet = ($urandom_range(0, 4) == 0);
      for (i = 0; i < len; i++) begin
         if (full_range)
            s = SAMPLE_W'($urandom);
         else if ($urandom_range(0, 99) < heavy_pct)
            s = pool[0];
         else
            s = pool[$urandom_range(0, pool_size - 1)];
         // the flag only matters on the last beat, toggle it elsewhere anyway
         send_sample(s, i == len - 1, (i == len - 1) ? flag : logic'($urandom_range(0, 1)));
      end
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin : main
      logic [SAMPLE_W-1:0] spread [10];
      int unsigned         i;
      int unsigned         leftover;
      bit                  hold_done;

      sb = new();
      hold_done = 1'b0;
      spread = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF,
                 16'h5555, 16'hAAAA, 16'd100, 16'hFF38, 16'd300};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed bands ---
      // single-sample band, always concentrated, flag blocked
      send_sample(16'h7FFF, 1'b1, 1'b1);
      // ten distinct values: exactly one tenth is not above one tenth
      for (i = 0; i < 10; i++) send_sample(spread[i], i == 9, 1'b1);
      // repeated value in a short band, flag low
      send_sample(16'd7, 1'b0, 1'b1);
      send_sample(16'd7, 1'b0, 1'b0);
      send_sample(16'hFFF9, 1'b1, 1'b0);
      // single most-negative sample with flag low
      send_sample(16'h8000, 1'b1, 1'b0);
      // ten evenly spread values, flag low: not concentrated, not allowed
      for (i = 0; i < 10; i++)
         send_sample(SAMPLE_W'(i * 6553 + 32768), i == 9, 1'b0);

      // --- random bands ---
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (!hold_done && items_sent >= RANDOM_ITEMS / 2) begin
            // sender pauses until everything is back, then the receiver
            // holds off while back-to-back single-sample bands pile up
            wait_idle(DRAIN_LIMIT);
            hold_rsp = 1'b1;
            tx_quiet = 1'b0;
            tx_quiet = 1'b1;
            for (i = 0; i < HOLD_BANDS; i++)
               send_sample(SAMPLE_W'($urandom), 1'b1, logic'($urandom_range(0, 1)));
            hold_done = 1'b1;
         end
         send_random_band();
      end

      // --- wind down ---
      wait_idle(DRAIN_LIMIT);
      repeat (TAIL_CYCLES) @(posedge clock);
      leftover = sb.pending();
      if (leftover != 0) $display("results still missing: %0d", leftover);
      if (sb.errors == 0 && leftover == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(64'(TIMEOUT_CYCLES) * 10);
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
